/* design/scv_pkg.sv */
// Shared constants and types for the session close location value block.
package scv_pkg;

  localparam int PRICE_BITS = 32;              // price datapath width
  localparam int FRAC_BITS  = 15;              // fraction bits of the result
  localparam int IN_W       = 32;              // width of price fields on the port
  localparam int OUT_W      = 17;              // width of clv_value on the port
  localparam int EXT_W      = (FRAC_BITS + 1 > OUT_W) ? FRAC_BITS + 1 : OUT_W;
  localparam int CNT_W      = $clog2(FRAC_BITS + 1);
  localparam int QDEPTH     = 2;               // session jobs between front and back
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [FRAC_BITS:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // One finished session, handed from front to back.
  typedef struct packed {
    logic [PRICE_BITS-1:0] high;
    logic [PRICE_BITS-1:0] low;
    logic [PRICE_BITS-1:0] close;
    logic                  ok;     // high, low and close all present
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* design/scv_if.sv */
// Request channels: price bars in, close location values out.
interface scv_in_if import scv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] high_price;
  logic            high_present;
  logic [IN_W-1:0] low_price;
  logic            low_present;
  logic [IN_W-1:0] close_price;
  logic            close_present;
  logic            last_in_session;

  modport source (output valid, high_price, high_present, low_price, low_present,
                  close_price, close_present, last_in_session, input ready);
  modport sink   (input valid, high_price, high_present, low_price, low_present,
                  close_price, close_present, last_in_session, output ready);
endinterface

interface scv_out_if import scv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] clv_value;
  logic                    clv_valid;

  modport source (output valid, clv_value, clv_valid, input ready);
  modport sink   (input valid, clv_value, clv_valid, output ready);
endinterface

/* design/scv_front.sv */
// Front end: takes bars, tracks session high/low, posts a job on the last bar.
module scv_front import scv_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  scv_in_if.sink        in_ch,
  input  qstat_t        qstat,
  output logic          push,
  output job_t          job
);

  logic [PRICE_BITS-1:0] running_high_r, running_high_nxt;
  logic [PRICE_BITS-1:0] running_low_r, running_low_nxt;
  logic                  high_seen_r, high_seen_nxt;
  logic                  low_seen_r, low_seen_nxt;

  logic [PRICE_BITS-1:0] h, l, hi_f, lo_f;
  logic                  hseen_f, lseen_f, acc;

  assign in_ch.ready = !qstat.full;
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    h       = PRICE_BITS'(in_ch.high_price);
    l       = PRICE_BITS'(in_ch.low_price);
    hi_f    = (in_ch.high_present && (!high_seen_r || h > running_high_r)) ? h
                                                                           : running_high_r;
    lo_f    = (in_ch.low_present && (!low_seen_r || l < running_low_r)) ? l
                                                                        : running_low_r;
    hseen_f = high_seen_r || in_ch.high_present;
    lseen_f = low_seen_r || in_ch.low_present;

    job.high  = hi_f;
    job.low   = lo_f;
    job.close = PRICE_BITS'(in_ch.close_price);
    job.ok    = hseen_f && lseen_f && in_ch.close_present;
    push      = acc && in_ch.last_in_session;

    running_high_nxt = running_high_r;
    running_low_nxt  = running_low_r;
    high_seen_nxt    = high_seen_r;
    low_seen_nxt     = low_seen_r;
    if (acc) begin
      if (in_ch.last_in_session) begin
        running_high_nxt = '0;
        running_low_nxt  = '1;
        high_seen_nxt    = 1'b0;
        low_seen_nxt     = 1'b0;
      end else begin
        running_high_nxt = hi_f;
        running_low_nxt  = lo_f;
        high_seen_nxt    = hseen_f;
        low_seen_nxt     = lseen_f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_high_r <= '0;
      running_low_r  <= '1;
      high_seen_r    <= 1'b0;
      low_seen_r     <= 1'b0;
    end else begin
      running_high_r <= running_high_nxt;
      running_low_r  <= running_low_nxt;
      high_seen_r    <= high_seen_nxt;
      low_seen_r     <= low_seen_nxt;
    end
  end

endmodule

/* design/scv_queue.sv */
// Short FIFO of session jobs between front and back.
module scv_queue import scv_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  job_t   push_job,
  input  logic   pop,
  output job_t   head,
  output qstat_t qstat
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

/* design/scv_back.sv */
// Back end: per-session CLV arithmetic, restoring divider, output register.
module scv_back import scv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  job_t     head,
  input  qstat_t   qstat,
  output logic     pop,
  scv_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_MAG, ST_SAT, ST_DIV, ST_OUT
  } state_t;

  state_t                  state_r;
  logic [PRICE_BITS-1:0]   high_r, low_r, close_r, den_r, rem_r;
  logic [PRICE_BITS:0]     sum_r, twoc_r, mag_r;
  logic                    ok_r, neg_r;
  logic [FRAC_BITS:0]      q_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    outv_r, clv_valid_r;
  logic signed [OUT_W-1:0] clv_value_r;

  logic [PRICE_BITS:0]     sh, diff;
  logic                    ge;
  logic [EXT_W-1:0]        q_ext, val_ext;

  assign pop = (state_r == ST_IDLE) && !qstat.empty;

  always_comb begin
    sh      = {rem_r, 1'b0};
    ge      = sh >= {1'b0, den_r};
    diff    = sh - {1'b0, den_r};
    q_ext   = EXT_W'(q_r);
    val_ext = neg_r ? (~q_ext + 1'b1) : q_ext;
  end

  assign out_ch.valid     = outv_r;
  assign out_ch.clv_value = clv_value_r;
  assign out_ch.clv_valid = clv_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      outv_r  <= 1'b0;
    end else begin
      // ST_OUT reloads the output register itself
      if (out_ch.valid && out_ch.ready && (state_r != ST_OUT)) outv_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            high_r  <= head.high;
            low_r   <= head.low;
            close_r <= head.close;
            ok_r    <= head.ok;
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          den_r   <= high_r - low_r;
          sum_r   <= {1'b0, high_r} + {1'b0, low_r};
          twoc_r  <= {close_r, 1'b0};
          ok_r    <= ok_r && (high_r > low_r);
          state_r <= ST_MAG;
        end
        ST_MAG: begin
          neg_r   <= twoc_r < sum_r;
          mag_r   <= (twoc_r < sum_r) ? (sum_r - twoc_r) : (twoc_r - sum_r);
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          if (!ok_r) begin
            q_r     <= '0;
            state_r <= ST_OUT;
          end else if (mag_r >= {1'b0, den_r}) begin
            q_r     <= Q_ONE;        // ratio at or beyond one: clamp
            state_r <= ST_OUT;
          end else begin
            rem_r   <= mag_r[PRICE_BITS-1:0];
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          q_r   <= {q_r[FRAC_BITS-1:0], ge};
          rem_r <= ge ? diff[PRICE_BITS-1:0] : sh[PRICE_BITS-1:0];
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(FRAC_BITS - 1)) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!outv_r || out_ch.ready) begin
            outv_r      <= 1'b1;
            clv_value_r <= val_ext[OUT_W-1:0];
            clv_valid_r <= ok_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/session_close_location_value.sv */
// Top level of the session close location value block.
//
// in_ch carries one price bar per request: high, low and close in ticks, each
// with a present flag, and last_in_session. out_ch carries one request per
// session: clv_value = (2c - H - L)/(H - L) * 2^15, truncated toward zero and
// clamped to +-32768, with clv_valid low when H or L was never seen, H <= L,
// or the last close is missing.
// Throughput: one bar per cycle while in_ch.ready is high. Each session end is
// handed to a two-entry job queue; the back end then takes the job, runs the
// setup states ST_PREP, ST_MAG and ST_SAT, computes one restoring-divider bit
// per cycle for FRAC_BITS bits, and registers the result in ST_OUT; a clamped or
// invalid result skips the divider. The back end takes a new job only in idle,
// so short sessions fill the queue, and in_ch.ready drops while it is full.
// Reset (rst_n low at a clock edge) clears the running high/low, the queue and
// the output valid flag. If out_ch.ready stays low, the finished result holds in
// the output register, the back end waits with the next one, the queue fills,
// and then the input stalls; bars inside a session still flow until then.
module session_close_location_value import scv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  scv_in_if.sink    in_ch,
  scv_out_if.source out_ch
);

  logic   push, pop;
  job_t   push_job, head;
  qstat_t qstat;

  // bar intake and running extremes
  scv_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push),
    .job   (push_job)
  );

  // decouples intake from the slow per-session math
  scv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // subtract, magnitude, clamp, divide, present
  scv_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // queue status is never both full and empty
  a_qstat: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue status full and empty at once");

  // a session end is never posted into a full queue
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("job posted to full queue");

  // back end takes one job, then is busy for at least the next cycle
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !pop)
    else $error("back end popped on consecutive cycles");

  // an invalid result always carries zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.clv_valid) |-> (out_ch.clv_value == '0))
    else $error("invalid result with nonzero value");

endmodule
